// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL of the bus SYN generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, disabled while reset is asserted.
`define BSG_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Concurrent check that also runs during reset.
`define BSG_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/core/bsg_pkg.sv -----
// Types, constants and helper functions of the bus SYN generator.
package bsg_pkg;

    localparam int CountW  = 17;
    localparam int CfgIdxW = 4;

    localparam logic [7:0] SYN_BYTE = 8'hAA;

    typedef enum logic [1:0] {
        FUNC_TICK = 2'd0,
        FUNC_RX   = 2'd1,
        FUNC_TX   = 2'd2,
        FUNC_NONE = 2'd3
    } t_func;

    typedef enum logic [CfgIdxW-1:0] {
        REG_SYN_ENABLE     = 4'd0,
        REG_OWN_ADDRESS    = 4'd1,
        REG_BASE_MS        = 4'd2,
        REG_TOLERANCE_MS   = 4'd3,
        REG_ADDR_FACTOR_MS = 4'd4,
        REG_CARRIER_MS     = 4'd5,
        REG_POSTPONE_MS    = 4'd6,
        REG_SERIAL_MS      = 4'd7
    } t_reg_idx;

    localparam logic [7:0] RST_OWN_ADDRESS = 8'd0;
    localparam logic [7:0] RST_BASE_MS     = 8'd40;
    localparam logic [7:0] RST_TOLERANCE   = 8'd10;
    localparam logic [7:0] RST_ADDR_FACTOR = 8'd10;
    localparam logic [7:0] RST_CARRIER_MS  = 8'd2;
    localparam logic [7:0] RST_POSTPONE_MS = 8'd1;
    localparam logic [7:0] RST_SERIAL_MS   = 8'd4;
    localparam logic [CountW-1:0] RST_COUNTDOWN =
        CountW'(RST_BASE_MS + RST_OWN_ADDRESS * RST_ADDR_FACTOR + RST_TOLERANCE);

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data_byte;
        logic       request_pending;
        logic [7:0] request_address;
    } t_in_item;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       rx_bus_request;
        logic       syn_sent;
        logic       syn_postponed;
    } t_out_item;

    typedef struct packed {
        logic       syn_enable;
        logic [7:0] own_address;
        logic [7:0] base_ms;
        logic [7:0] tol_ms;
        logic [7:0] addr_step_ms;
        logic [7:0] quiet_ms;
        logic [7:0] retry_ms;
        logic [7:0] serialization_ms;
    } t_cfg;

    typedef struct packed {
        logic              syn_active;
        logic [CountW-1:0] countdown_ms;
        logic [7:0]        idle_ms;
        logic              request_sent_flag;
    } t_state;

    // Unique interval: base + address * factor + tolerance, at most 16 bits.
    function automatic logic [CountW-1:0] f_unique(input t_cfg cfg);
        logic [15:0] prod;
        prod = {8'd0, cfg.own_address} * {8'd0, cfg.addr_step_ms};
        return CountW'(prod) + CountW'(cfg.base_ms) + CountW'(cfg.tol_ms);
    endfunction

endpackage

// ----- rtl/core/bsg_step.sv -----
// Per-beat state update and result of the bus SYN generator.
module bsg_step import bsg_pkg::*; (
    input  t_cfg      i_cfg,
    input  t_state    i_state,
    input  t_in_item  i_item,
    output t_state    o_state,
    output t_out_item o_result
);

    logic [CountW-1:0] unique_ms;
    logic [CountW-1:0] reload_tx;
    logic [CountW-1:0] count_dec;
    logic [7:0]        idle_inc;
    t_func             func;

    assign unique_ms = f_unique(i_cfg);
    assign reload_tx = unique_ms + CountW'(i_cfg.serialization_ms);
    assign count_dec = (i_state.countdown_ms != '0) ? i_state.countdown_ms - 1'b1 : '0;
    assign idle_inc  = (i_state.idle_ms != 8'hFF) ? i_state.idle_ms + 8'd1 : 8'hFF;
    assign func      = t_func'(i_item.func);

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        case (func)
            FUNC_TICK: begin
                o_state.idle_ms      = idle_inc;
                o_state.countdown_ms = count_dec;
                if (count_dec == '0 && i_cfg.syn_enable) begin
                    if (idle_inc < i_cfg.quiet_ms) begin
                        o_state.countdown_ms   = CountW'(i_cfg.retry_ms);
                        o_result.syn_postponed = 1'b1;
                    end else begin
                        o_state.syn_active   = 1'b1;
                        o_state.idle_ms      = '0;
                        o_state.countdown_ms = reload_tx;
                        o_result.tx_valid    = 1'b1;
                        o_result.tx_byte     = SYN_BYTE;
                        o_result.syn_sent    = 1'b1;
                    end
                end
            end
            FUNC_RX: begin
                o_state.idle_ms = '0;
                if (i_state.syn_active && i_item.data_byte == SYN_BYTE) begin
                    o_state.countdown_ms = CountW'(i_cfg.base_ms);
                end else begin
                    o_state.syn_active   = 1'b0;
                    o_state.countdown_ms = unique_ms;
                end
                o_result.rx_bus_request   = i_state.request_sent_flag;
                o_state.request_sent_flag = 1'b0;
                // SYN seen with a pending request: claim the bus right away.
                if (i_item.data_byte == SYN_BYTE && i_item.request_pending) begin
                    if (i_item.request_address != SYN_BYTE) begin
                        o_state.syn_active = 1'b0;
                    end
                    o_state.countdown_ms      = reload_tx;
                    o_state.request_sent_flag = 1'b1;
                    o_result.tx_valid         = 1'b1;
                    o_result.tx_byte          = i_item.request_address;
                end
            end
            FUNC_TX: begin
                o_state.idle_ms = '0;
                if (i_item.data_byte != SYN_BYTE) begin
                    o_state.syn_active = 1'b0;
                end
                o_state.countdown_ms = reload_tx;
                o_result.tx_valid    = 1'b1;
                o_result.tx_byte     = i_item.data_byte;
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- rtl/core/bus_syn_generator_unit.sv -----
// Top level of the bus SYN generator: beat registers, state and config registers.
// Each input beat (millisecond tick, received byte or host byte) is taken into
// an input register and produces exactly one result beat in the result register,
// where the whole state update is one pass of short logic around an 8x8
// multiply for the unique interval. A new beat is accepted every cycle while
// the result register drains; a stalled result holds the input register, so
// throughput is one beat per clock while results are taken. Configuration
// writes are taken only while no beat sits in the input register; writing
// syn_enable from 0 to 1 reloads the countdown, and any write to one of the
// other seven registers with generation enabled realigns the timer.
`include "assert_macros.svh"

module bus_syn_generator_unit import bsg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [7:0]         i_cfg_data
);

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;
    t_cfg      r_cfg;
    t_cfg      n_cfg;
    t_state    r_state;
    t_state    n_state;
    t_state    step_state;
    logic      proc;
    logic      cfg_we;
    t_reg_idx  cfg_idx;

    assign proc        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || proc;
    assign o_cfg_ready = !r_in_valid;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign cfg_idx     = t_reg_idx'(i_cfg_index);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    bsg_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_item   (r_in),
        .o_state  (step_state),
        .o_result (n_out)
    );

    // State update of a processed beat, or config write and realign of the timer.
    always_comb begin
        n_cfg   = r_cfg;
        n_state = r_state;
        if (proc) begin
            n_state = step_state;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_SYN_ENABLE:     n_cfg.syn_enable        = i_cfg_data[0];
                REG_OWN_ADDRESS:    n_cfg.own_address       = i_cfg_data;
                REG_BASE_MS:        n_cfg.base_ms           = i_cfg_data;
                REG_TOLERANCE_MS:   n_cfg.tol_ms            = i_cfg_data;
                REG_ADDR_FACTOR_MS: n_cfg.addr_step_ms      = i_cfg_data;
                REG_CARRIER_MS:     n_cfg.quiet_ms          = i_cfg_data;
                REG_POSTPONE_MS:    n_cfg.retry_ms          = i_cfg_data;
                REG_SERIAL_MS:      n_cfg.serialization_ms  = i_cfg_data;
                default: begin
                end
            endcase
            if (cfg_idx == REG_SYN_ENABLE) begin
                if (i_cfg_data[0] && !r_cfg.syn_enable) begin
                    n_state.countdown_ms = f_unique(r_cfg);
                    n_state.syn_active   = 1'b0;
                end
            end else if (i_cfg_index < CfgIdxW'(8) && r_cfg.syn_enable) begin
                n_state.idle_ms = '0;
                if (r_state.syn_active) begin
                    n_state.countdown_ms = CountW'(n_cfg.base_ms);
                end else begin
                    n_state.countdown_ms = f_unique(n_cfg);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cfg       <= '{syn_enable: 1'b0, own_address: RST_OWN_ADDRESS,
                             base_ms: RST_BASE_MS, tol_ms: RST_TOLERANCE,
                             addr_step_ms: RST_ADDR_FACTOR,
                             quiet_ms: RST_CARRIER_MS,
                             retry_ms: RST_POSTPONE_MS,
                             serialization_ms: RST_SERIAL_MS};
            r_state     <= '{syn_active: 1'b0, countdown_ms: RST_COUNTDOWN,
                             idle_ms: 8'd0, request_sent_flag: 1'b0};
        end else begin
            r_cfg   <= n_cfg;
            r_state <= n_state;
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            // Load a result on processing, drop it once taken.
            if (proc) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (proc) begin
            r_out <= n_out;
        end
    end

    `BSG_ASSERT(a_syn_is_tx, r_out_valid |-> (!r_out.syn_sent || (r_out.tx_valid && r_out.tx_byte == SYN_BYTE)), "SYN flag without SYN byte")
    `BSG_ASSERT(a_sent_xor_post, r_out_valid |-> !(r_out.syn_sent && r_out.syn_postponed), "SYN sent and postponed together")
    `BSG_ASSERT(a_hold_input, (r_in_valid && !proc) |=> (r_in_valid && $stable(r_in)), "stalled input beat lost")
    `BSG_ASSERT_ALWAYS(a_cfg_idle, (i_rst_n && cfg_we) |-> !proc, "config write during processing")

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench of the bus SYN generator: predicts every result beat and compares.
`timescale 1ns / 100ps

module tb;
    import bsg_pkg::*;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    t_in_item            i_in_data = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    t_out_item           o_out_data;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CfgIdxW-1:0]  i_cfg_index = '0;
    logic [7:0]          i_cfg_data = '0;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;

    // Timer state of the generator, kept in step with accepted beats.
    class syn_timer_model;
        t_cfg              cfg;
        logic              syn_active;
        logic [CountW-1:0] countdown_ms;
        logic [7:0]        idle_ms;
        logic              req_flag;
        t_out_item         pending_outcomes[$];
        t_out_item         last_outcome;
        int errors, beats, results, syn_count, postpone_count, busreq_count;

        function new();
            cfg = '{1'b0, RST_OWN_ADDRESS, RST_BASE_MS, RST_TOLERANCE, RST_ADDR_FACTOR,
                    RST_CARRIER_MS, RST_POSTPONE_MS, RST_SERIAL_MS};
            syn_active = 1'b0;
            idle_ms = '0;
            req_flag = 1'b0;
            countdown_ms = unique_ms();
            last_outcome = '0;
            errors = 0;
            beats = 0;
            results = 0;
            syn_count = 0;
            postpone_count = 0;
            busreq_count = 0;
        endfunction

        function logic [CountW-1:0] unique_ms();
            return CountW'(cfg.base_ms) + CountW'(cfg.own_address) * CountW'(cfg.addr_step_ms)
                   + CountW'(cfg.tol_ms);
        endfunction

        function void report(input string msg);
            errors++;
            if (errors <= 10)
                $display("ERROR: %s", msg);
        endfunction

        function void heard_byte(input logic [7:0] b);
            idle_ms = '0;
            if (syn_active && b == SYN_BYTE) begin
                countdown_ms = CountW'(cfg.base_ms);
            end else begin
                syn_active = 1'b0;
                countdown_ms = unique_ms();
            end
        endfunction

        function void sent_byte(input logic [7:0] b);
            idle_ms = '0;
            if (b != SYN_BYTE)
                syn_active = 1'b0;
            countdown_ms = unique_ms() + CountW'(cfg.serialization_ms);
        endfunction

        function void write_reg(input t_reg_idx idx, input logic [7:0] v);
            logic prev_enable;
            prev_enable = cfg.syn_enable;
            case (idx)
                REG_SYN_ENABLE:     cfg.syn_enable = v[0];
                REG_OWN_ADDRESS:    cfg.own_address = v;
                REG_BASE_MS:        cfg.base_ms = v;
                REG_TOLERANCE_MS:   cfg.tol_ms = v;
                REG_ADDR_FACTOR_MS: cfg.addr_step_ms = v;
                REG_CARRIER_MS:     cfg.quiet_ms = v;
                REG_POSTPONE_MS:    cfg.retry_ms = v;
                default:            cfg.serialization_ms = v;
            endcase
            if (idx == REG_SYN_ENABLE) begin
                if (cfg.syn_enable && !prev_enable) begin
                    countdown_ms = unique_ms();
                    syn_active = 1'b0;
                end
            end else if (cfg.syn_enable) begin
                // realign the timer as on a received SYN
                heard_byte(SYN_BYTE);
            end
        endfunction

        function void predict_beat(input t_in_item b);
            t_out_item p;
            p = '0;
            case (b.func)
                FUNC_TICK: begin
                    if (idle_ms != 8'hFF)
                        idle_ms = idle_ms + 8'd1;
                    if (countdown_ms != 0)
                        countdown_ms = countdown_ms - 1'b1;
                    if (countdown_ms == 0 && cfg.syn_enable) begin
                        if (idle_ms < cfg.quiet_ms) begin
                            countdown_ms = CountW'(cfg.retry_ms);
                            p.syn_postponed = 1'b1;
                        end else begin
                            syn_active = 1'b1;
                            sent_byte(SYN_BYTE);
                            p.tx_valid = 1'b1;
                            p.tx_byte = SYN_BYTE;
                            p.syn_sent = 1'b1;
                        end
                    end
                end
                FUNC_RX: begin
                    heard_byte(b.data_byte);
                    p.rx_bus_request = req_flag;
                    req_flag = 1'b0;
                    if (b.data_byte == SYN_BYTE && b.request_pending) begin
                        sent_byte(b.request_address);
                        req_flag = 1'b1;
                        p.tx_valid = 1'b1;
                        p.tx_byte = b.request_address;
                    end
                end
                FUNC_TX: begin
                    sent_byte(b.data_byte);
                    p.tx_valid = 1'b1;
                    p.tx_byte = b.data_byte;
                end
                default: ;
            endcase
            pending_outcomes.push_back(p);
            last_outcome = p;
            beats++;
        endfunction

        function void check_outcome(input t_out_item got);
            t_out_item want;
            results++;
            if (got.syn_sent === 1'b1) syn_count++;
            if (got.syn_postponed === 1'b1) postpone_count++;
            if (got.rx_bus_request === 1'b1) busreq_count++;
            if (pending_outcomes.size() == 0) begin
                report($sformatf("result %0d arrived with nothing expected: %p", results, got));
                return;
            end
            want = pending_outcomes.pop_front();
            if (got.tx_valid !== want.tx_valid || got.tx_byte !== want.tx_byte ||
                    got.rx_bus_request !== want.rx_bus_request ||
                    got.syn_sent !== want.syn_sent || got.syn_postponed !== want.syn_postponed)
                report($sformatf({"result %0d: expected tx_valid=%0b tx_byte=%02h rx_req=%0b ",
                    "syn_sent=%0b postponed=%0b, got tx_valid=%0b tx_byte=%02h rx_req=%0b ",
                    "syn_sent=%0b postponed=%0b"}, results,
                    want.tx_valid, want.tx_byte, want.rx_bus_request, want.syn_sent,
                    want.syn_postponed, got.tx_valid, got.tx_byte, got.rx_bus_request,
                    got.syn_sent, got.syn_postponed));
        endfunction

        function void close();
            if (pending_outcomes.size() != 0)
                report($sformatf("%0d expected results never arrived", pending_outcomes.size()));
        endfunction
    endclass

    syn_timer_model model;

    bus_syn_generator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Result side: check each beat taken, then pick ready for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            model.check_outcome(o_out_data);
        if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= 48;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic t_in_item beat(input t_func f, input logic [7:0] d, input logic req,
                                      input logic [7:0] addr);
        t_in_item b;
        b.func = f;
        b.data_byte = d;
        b.request_pending = req;
        b.request_address = addr;
        return b;
    endfunction

    // Mostly bus-like traffic: echo what was just sent, SYNs, ticks, some noise.
    function automatic t_in_item random_beat(input bit ticks_only);
        t_in_item b;
        int r;
        b = beat(FUNC_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)),
                 8'($urandom_range(255)));
        r = $urandom_range(99);
        if (ticks_only) begin
            if (r >= 95) b.func = FUNC_NONE;
        end else if (model.last_outcome.tx_valid && r < 75) begin
            b.func = FUNC_RX;
            b.data_byte = model.last_outcome.tx_byte;
        end else if (r < 50) begin
            b.func = FUNC_TICK;
        end else if (r < 80) begin
            b.func = FUNC_RX;
            if ($urandom_range(1)) b.data_byte = SYN_BYTE;
        end else if (r < 93) begin
            b.func = FUNC_TX;
        end else begin
            b.func = FUNC_NONE;
        end
        return b;
    endfunction

    function automatic logic [7:0] reg_value(input t_cfg c, input t_reg_idx idx);
        case (idx)
            REG_SYN_ENABLE:     return {7'd0, c.syn_enable};
            REG_OWN_ADDRESS:    return c.own_address;
            REG_BASE_MS:        return c.base_ms;
            REG_TOLERANCE_MS:   return c.tol_ms;
            REG_ADDR_FACTOR_MS: return c.addr_step_ms;
            REG_CARRIER_MS:     return c.quiet_ms;
            REG_POSTPONE_MS:    return c.retry_ms;
            default:            return c.serialization_ms;
        endcase
    endfunction

    function automatic t_cfg phase_cfg(input int p);
        case (p)
            0: return '{1'b1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd0};
            1: return '{1'b1, RST_OWN_ADDRESS, RST_BASE_MS, RST_TOLERANCE, RST_ADDR_FACTOR,
                        RST_CARRIER_MS, RST_POSTPONE_MS, RST_SERIAL_MS};
            2: return '{1'b1, 8'd0, 8'd3, 8'd0, 8'd0, 8'd2, 8'd0, 8'd0};
            3: return '{1'b1, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
            4: return '{1'b1, 8'd2, 8'd5, 8'd1, 8'd3, 8'd0, 8'd3, 8'd1};
            5: return '{1'b1, 8'd1, 8'd1, 8'd0, 8'd1, 8'd255, 8'd1, 8'd0};
            6: return '{1'b0, 8'd0, 8'd2, 8'd1, 8'd0, 8'd1, 8'd1, 8'd1};
            default: return '{1'b1, 8'd4, 8'd6, 8'd2, 8'd2, 8'd3, 8'd2, 8'd2};
        endcase
    endfunction

    task automatic send_beat(input t_in_item b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= b;
        do @(posedge i_clk); while (!o_in_ready);
        model.predict_beat(b);
    endtask

    // Wait until every expected beat is back, then let the pipeline settle.
    task automatic wait_drained();
        do @(posedge i_clk); while (model.pending_outcomes.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_config(input t_cfg c);
        t_reg_idx idx;
        logic [7:0] v;
        idx = REG_SYN_ENABLE;
        repeat (8) begin
            v = reg_value(c, idx);
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data <= v;
            do @(posedge i_clk); while (!o_cfg_ready);
            model.write_reg(idx, v);
            idx = idx.next();
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int p, input int n, input bit ticks_only,
                             input int s_pct, input int r_pct, input bit pressure);
        wait_drained();
        load_config(phase_cfg(p));
        send_idle_pct = s_pct;
        stall_pct = r_pct;
        for (int k = 0; k < n; k++) begin
            if (pressure && k == n / 3)
                hold_req <= hold_req + 1;
            if (pressure && k == 2 * n / 3) begin
                i_in_valid <= 1'b0;
                wait_drained();
            end
            send_beat(random_beat(ticks_only));
        end
        i_in_valid <= 1'b0;
    endtask

    initial begin
        model = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // generation still disabled: unused code, host bytes, requests, tags
        send_beat(beat(FUNC_NONE, 8'hFF, 1'b1, 8'hFF));
        send_beat(beat(FUNC_TICK, 8'h00, 1'b0, 8'h00));
        send_beat(beat(FUNC_TX, 8'hFF, 1'b1, 8'h00));
        send_beat(beat(FUNC_TX, 8'h00, 1'b0, 8'hFF));
        send_beat(beat(FUNC_RX, SYN_BYTE, 1'b1, 8'hFF));
        send_beat(beat(FUNC_RX, 8'h00, 1'b0, 8'h00));
        send_beat(beat(FUNC_RX, SYN_BYTE, 1'b1, SYN_BYTE));
        send_beat(beat(FUNC_RX, SYN_BYTE, 1'b0, 8'h00));
        send_beat(beat(FUNC_RX, 8'h55, 1'b1, 8'h12));
        send_beat(beat(FUNC_RX, 8'hFF, 1'b1, 8'hFF));
        i_in_valid <= 1'b0;

        // enable with zero intervals: SYN on every tick, echo and request
        wait_drained();
        load_config(phase_cfg(0));
        send_beat(beat(FUNC_TICK, 8'h00, 1'b0, 8'h00));
        send_beat(beat(FUNC_TICK, 8'hFF, 1'b1, 8'hFF));
        send_beat(beat(FUNC_RX, SYN_BYTE, 1'b0, 8'h00));
        send_beat(beat(FUNC_TICK, 8'h00, 1'b0, 8'h00));
        send_beat(beat(FUNC_RX, SYN_BYTE, 1'b1, 8'h33));
        send_beat(beat(FUNC_RX, 8'h33, 1'b0, 8'h00));
        send_beat(beat(FUNC_TICK, 8'h00, 1'b0, 8'h00));
        send_beat(beat(FUNC_TX, 8'h10, 1'b0, 8'h00));
        send_beat(beat(FUNC_TICK, 8'h00, 1'b0, 8'h00));
        i_in_valid <= 1'b0;

        run_phase(1, 40, 1'b0, 0, 0, 1'b0);
        run_phase(2, 70, 1'b0, 69, 0, 1'b0);
        run_phase(3, 70, 1'b0, 0, 69, 1'b0);
        run_phase(4, 120, 1'b0, 36, 36, 1'b1);
        run_phase(5, 280, 1'b1, 0, 0, 1'b0);
        run_phase(6, 60, 1'b0, 69, 69, 1'b0);
        run_phase(7, 40, 1'b0, 0, 0, 1'b0);

        wait_drained();
        model.close();
        $display("Run covered %0d beats and %0d results over 8 register settings",
                 model.beats, model.results);
        $display("Seen: %0d generated SYNs, %0d postponements, %0d tagged bus requests",
                 model.syn_count, model.postpone_count, model.busreq_count);
        if (model.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout: handshakes stopped progressing");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
